// File: design/occupancy_grid_inflate_unit_macros.svh
// Assertion macros for the occupancy grid inflate unit
`ifndef OCCUPANCY_GRID_INFLATE_UNIT_MACROS_SVH
`define OCCUPANCY_GRID_INFLATE_UNIT_MACROS_SVH

// same-cycle implication
`define OGI_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("occupancy grid check failed");

// next-cycle implication
`define OGI_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("occupancy grid sequence check failed");

`endif

// File: design/ogi_pkg.sv
// Shared constants, codes and types for the occupancy grid inflate unit
package ogi_pkg;

  localparam int FORWARD_CELLS = 200;
  localparam int LATERAL_CELLS = 201;

  localparam int RW = $clog2(LATERAL_CELLS);
  localparam int CW = $clog2(FORWARD_CELLS);

  localparam int XMIN_MM       = 1500;
  localparam int XMAX_MM       = (FORWARD_CELLS / 10) * 1000;
  localparam int YMAX_MM       = (((LATERAL_CELLS - 1) / 10) / 2) * 1000;
  localparam int GROUND_MARGIN = 200;

  // x / 100 as (x * 5243) >> 19, exact for magnitudes below 43699
  localparam int DIV_MUL   = 5243;
  localparam int DIV_MUL_W = 13;
  localparam int DIV_SH    = 19;
  localparam int OPA_W     = 16;
  localparam int PROD_W    = OPA_W + DIV_MUL_W;
  localparam int Q_W       = 9;

  localparam int SW = $clog2(FORWARD_CELLS + LATERAL_CELLS + 64 + 2 ** Q_W) + 1;

  localparam int HEIGHT_W  = 13;
  localparam int HALF_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = HEIGHT_W;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(1000);
  localparam logic [HALF_W-1:0]   HALF_RST   = HALF_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_LIDAR_HEIGHT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INFLATE_HALF = CFG_IDX_W'(1);

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic          clr;
    logic          rd_en;
    logic [RW-1:0] rd_addr;
    logic          wr_en;
    logic [RW-1:0] wr_addr;
  } mem_ctl_t;

endpackage

// File: design/ogi_div100.sv
// Shared reciprocal-multiply unit: registered quotient of a magnitude by 100
module ogi_div100 (
  input  logic                      clk,
  input  logic [ogi_pkg::OPA_W-1:0] op_a,
  output logic [ogi_pkg::Q_W-1:0]   quot
);
  import ogi_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    quot_r;

  assign prod = PROD_W'(op_a) * PROD_W'(DIV_MUL);

  always_ff @(posedge clk) begin
    quot_r <= prod[DIV_SH +: Q_W];
  end

  assign quot = quot_r;
endmodule

// File: design/ogi_row_mem.sv
// Grid row memory with per-row valid bits, so that a clear empties all rows at once
module ogi_row_mem (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ogi_pkg::mem_ctl_t                 ctl,
  input  logic [ogi_pkg::FORWARD_CELLS-1:0] wr_data,
  output logic [ogi_pkg::FORWARD_CELLS-1:0] rd_data
);
  import ogi_pkg::*;

  logic [FORWARD_CELLS-1:0] mem_r [LATERAL_CELLS];
  logic [LATERAL_CELLS-1:0] valid_r;
  logic [FORWARD_CELLS-1:0] rdata_r;
  logic                     rvalid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem_r[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (ctl.clr) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rvalid_r <= valid_r[ctl.rd_addr];
      end
    end
  end

  // rows never written since the last clear read as empty
  assign rd_data = rvalid_r ? rdata_r : '0;
endmodule

// File: design/occupancy_grid_inflate_unit.sv
// Top level: occupancy grid with square inflation around added points
//
// Input: an item is taken at a rising edge with start high and busy low.
// in_func selects clear grid, add point or read cell; code 3 does nothing.
// Output: one result per item, on out_occupied / out_point_marked while
// out_valid is high for one cycle. The receiver cannot stall the block.
// Clear, unused code, out-of-range read and a gated-out point
// give their result in the cycle after the accept (busy stays low).
// An in-range read goes through the registered memory read, then the output register.
// An accepted point makes two passes through the shared divide-by-100
// multiplier, goes through the set-up and bounds states, then paints one
// grid row per cycle through a pipelined read-modify-write of the row
// memory, up to 2*inflate_half+1 rows.
// Reset clears the per-row valid bits at once, so the grid reads empty
// right after reset; no clearing pass. Configuration: cfg_we writes
// cfg_wdata into register cfg_index (0 lidar height, 1 inflate half).
`include "occupancy_grid_inflate_unit_macros.svh"
module occupancy_grid_inflate_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic signed [15:0]            in_x_mm,
  input  logic signed [15:0]            in_y_mm,
  input  logic signed [15:0]            in_z_mm,
  input  logic [7:0]                    in_read_row,
  input  logic [7:0]                    in_read_col,
  output logic                          out_valid,
  output logic                          out_occupied,
  output logic                          out_point_marked,
  input  logic                          cfg_we,
  input  logic [ogi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ogi_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import ogi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RDWAIT, S_DIVX, S_DIVY, S_SETUP, S_BOUNDS, S_PAINT, S_DRAIN
  } state_t;

  state_t                   state_r, state_nxt;
  logic [HEIGHT_W-1:0]      height_r, height_nxt;
  logic [HALF_W-1:0]        half_r, half_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_occ_r, out_occ_nxt;
  logic                     out_mark_r, out_mark_nxt;
  logic                     pend_r, pend_nxt;

  logic [OPA_W-1:0]         x_r, x_nxt;
  logic [OPA_W-1:0]         ay_r, ay_nxt;
  logic                     yneg_r, yneg_nxt;
  logic [Q_W-1:0]           qx_r, qx_nxt;
  logic signed [SW-1:0]     row_r, row_nxt;
  logic signed [SW-1:0]     col_r, col_nxt;
  logic [RW-1:0]            bot_r, bot_nxt;
  logic [RW-1:0]            rd_row_r, rd_row_nxt;
  logic [RW-1:0]            pend_row_r, pend_row_nxt;
  logic [CW-1:0]            rcol_r, rcol_nxt;
  logic [FORWARD_CELLS-1:0] mask_r, mask_nxt;

  logic [OPA_W-1:0]         div_a;
  logic [Q_W-1:0]           div_q;
  mem_ctl_t                 mem_ctl;
  logic [FORWARD_CELLS-1:0] rd_data;
  logic [FORWARD_CELLS-1:0] wr_data;

  logic                     accept;
  int                       xs, ys, zs, ays, ground;
  logic                     pass;
  logic                     rd_in_range;
  logic signed [SW-1:0]     half_s, sy, top_s, bot_s, left_s, right_s, jj;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign xs     = int'(in_x_mm);
  assign ys     = int'(in_y_mm);
  assign zs     = int'(in_z_mm);
  assign ays    = (ys < 0) ? -ys : ys;
  assign ground = -(int'(height_r) + GROUND_MARGIN);
  assign pass   = (zs >= ground) && (ays < YMAX_MM) && (xs > XMIN_MM) && (xs < XMAX_MM);

  assign rd_in_range = (int'(in_read_row) < LATERAL_CELLS) &&
                       (int'(in_read_col) < FORWARD_CELLS);

  assign half_s  = signed'(SW'(half_r));
  assign sy      = yneg_r ? -signed'(SW'(div_q)) : signed'(SW'(div_q));
  assign top_s   = row_r - half_s;
  assign bot_s   = row_r + half_s;
  assign left_s  = col_r - half_s;
  assign right_s = col_r + half_s;

  assign div_a   = (state_r == S_DIVY) ? ay_r : x_r;
  assign wr_data = rd_data | mask_r;

  ogi_div100 u_div (
    .clk  (clk),
    .op_a (div_a),
    .quot (div_q)
  );

  ogi_row_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    height_nxt    = height_r;
    half_nxt      = half_r;
    out_valid_nxt = 1'b0;
    out_occ_nxt   = 1'b0;
    out_mark_nxt  = 1'b0;
    pend_nxt      = 1'b0;
    x_nxt         = x_r;
    ay_nxt        = ay_r;
    yneg_nxt      = yneg_r;
    qx_nxt        = qx_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    bot_nxt       = bot_r;
    rd_row_nxt    = rd_row_r;
    pend_row_nxt  = pend_row_r;
    rcol_nxt      = rcol_r;
    mask_nxt      = mask_r;
    jj            = '0;

    mem_ctl         = '0;
    mem_ctl.wr_en   = pend_r;
    mem_ctl.wr_addr = pend_row_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_LIDAR_HEIGHT: height_nxt = cfg_wdata[HEIGHT_W-1:0];
        CFG_INFLATE_HALF: half_nxt   = cfg_wdata[HALF_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_CLEAR: begin
              mem_ctl.clr   = 1'b1;
              out_valid_nxt = 1'b1;
            end
            FUNC_ADD: begin
              x_nxt    = in_x_mm[OPA_W-1:0];
              ay_nxt   = OPA_W'(ays);
              yneg_nxt = in_y_mm[15];
              if (pass) begin
                state_nxt = S_DIVX;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            FUNC_READ: begin
              if (rd_in_range) begin
                mem_ctl.rd_en   = 1'b1;
                mem_ctl.rd_addr = RW'(in_read_row);
                rcol_nxt        = CW'(in_read_col);
                state_nxt       = S_RDWAIT;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_RDWAIT: begin
        out_valid_nxt = 1'b1;
        out_occ_nxt   = rd_data[rcol_r];
        state_nxt     = S_IDLE;
      end
      S_DIVX: begin
        state_nxt = S_DIVY;
      end
      S_DIVY: begin
        qx_nxt    = div_q;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        row_nxt   = signed'(SW'(FORWARD_CELLS)) - signed'(SW'(qx_r));
        col_nxt   = signed'(SW'(LATERAL_CELLS / 2)) - sy;
        state_nxt = S_BOUNDS;
      end
      S_BOUNDS: begin
        bot_nxt    = (bot_s > SW'(LATERAL_CELLS - 1)) ? RW'(LATERAL_CELLS - 1) : RW'(bot_s);
        rd_row_nxt = (top_s < 0) ? '0 : RW'(top_s);
        for (int j = 0; j < FORWARD_CELLS; j++) begin
          jj          = SW'(j);
          mask_nxt[j] = (jj >= left_s) && (jj <= right_s);
        end
        // square lies wholly outside the grid rows
        if ((top_s > SW'(LATERAL_CELLS - 1)) || (bot_s < 0)) begin
          state_nxt = S_DRAIN;
        end else begin
          state_nxt = S_PAINT;
        end
      end
      S_PAINT: begin
        mem_ctl.rd_en   = 1'b1;
        mem_ctl.rd_addr = rd_row_r;
        pend_nxt        = 1'b1;
        pend_row_nxt    = rd_row_r;
        if (rd_row_r == bot_r) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_row_nxt = RW'(rd_row_r + 1'b1);
        end
      end
      S_DRAIN: begin
        out_valid_nxt = 1'b1;
        out_mark_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      height_r    <= HEIGHT_RST;
      half_r      <= HALF_RST;
      out_valid_r <= 1'b0;
      out_occ_r   <= 1'b0;
      out_mark_r  <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      height_r    <= height_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
      out_occ_r   <= out_occ_nxt;
      out_mark_r  <= out_mark_nxt;
      pend_r      <= pend_nxt;
    end
    x_r        <= x_nxt;
    ay_r       <= ay_nxt;
    yneg_r     <= yneg_nxt;
    qx_r       <= qx_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    bot_r      <= bot_nxt;
    rd_row_r   <= rd_row_nxt;
    pend_row_r <= pend_row_nxt;
    rcol_r     <= rcol_nxt;
    mask_r     <= mask_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_occupied     = out_occ_r;
  assign out_point_marked = out_mark_r;

  `OGI_ASSERT_SAME(a_result_exclusive, out_valid, !(out_occupied && out_point_marked))
  `OGI_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid)
  `OGI_ASSERT_SAME(a_write_in_paint, mem_ctl.wr_en, state_r == S_PAINT || state_r == S_DRAIN)
  `OGI_ASSERT_SAME(a_result_when_idle, out_valid, !busy)
endmodule

// File: test/tb_occupancy_grid_inflate_unit.sv
// Self-checking testbench for the occupancy grid inflate unit, directed and random beats
module tb_occupancy_grid_inflate_unit;
  import ogi_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PHASES = 8;

  typedef struct {
    logic [1:0]         func;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic signed [15:0] z_mm;
    logic [7:0]         read_row;
    logic [7:0]         read_col;
  } grid_op_t;

  typedef struct {
    logic [1:0] func;
    logic       occupied;
    logic       point_marked;
  } cell_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_func = FUNC_CLEAR;
  logic signed [15:0]   in_x_mm = '0;
  logic signed [15:0]   in_y_mm = '0;
  logic signed [15:0]   in_z_mm = '0;
  logic [7:0]           in_read_row = '0;
  logic [7:0]           in_read_col = '0;
  logic                 out_valid;
  logic                 out_occupied;
  logic                 out_point_marked;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LIDAR_HEIGHT;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  // predictor state
  int grid_height_mm = 1000;
  int grid_half = 10;
  bit occ_cells [LATERAL_CELLS][FORWARD_CELLS];

  grid_op_t     pending_ops [$];
  cell_result_t expected_cells [$];
  grid_op_t     cur_op;
  int           beats_sent = 0;
  int           idle_left = 0;
  int           burst_left = 0;

  int mismatches = 0;
  int n_beats = 0, n_clears = 0, n_painted = 0, n_dropped = 0, n_unused = 0;
  int n_reads = 0, n_read_set = 0, n_read_oor = 0, n_settings = 1;

  occupancy_grid_inflate_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_x_mm          (in_x_mm),
    .in_y_mm          (in_y_mm),
    .in_z_mm          (in_z_mm),
    .in_read_row      (in_read_row),
    .in_read_col      (in_read_col),
    .out_valid        (out_valid),
    .out_occupied     (out_occupied),
    .out_point_marked (out_point_marked),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic cell_result_t apply_grid_op(grid_op_t op);
    cell_result_t res;
    int x, y, z, ay, r, c, top, bot, lft, rgt;
    res.func = op.func;
    res.occupied = 1'b0;
    res.point_marked = 1'b0;
    x = op.x_mm;
    y = op.y_mm;
    z = op.z_mm;
    case (op.func)
      FUNC_CLEAR: begin
        foreach (occ_cells[i, j]) occ_cells[i][j] = 1'b0;
      end
      FUNC_ADD: begin
        ay = (y < 0) ? -y : y;
        if (z >= -(grid_height_mm + 200) && ay < ((LATERAL_CELLS - 1) / 10 / 2) * 1000 &&
            x > 1500 && x < (FORWARD_CELLS / 10) * 1000) begin
          r = FORWARD_CELLS - x / 100;
          c = LATERAL_CELLS / 2 - y / 100;
          top = (r - grid_half < 0) ? 0 : r - grid_half;
          lft = (c - grid_half < 0) ? 0 : c - grid_half;
          bot = (r + grid_half > LATERAL_CELLS - 1) ? LATERAL_CELLS - 1 : r + grid_half;
          rgt = (c + grid_half > FORWARD_CELLS - 1) ? FORWARD_CELLS - 1 : c + grid_half;
          for (int i = top; i <= bot; i++)
            for (int j = lft; j <= rgt; j++)
              occ_cells[i][j] = 1'b1;
          res.point_marked = 1'b1;
        end
      end
      FUNC_READ: begin
        if (op.read_row < LATERAL_CELLS && op.read_col < FORWARD_CELLS)
          res.occupied = occ_cells[op.read_row][op.read_col];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic grid_op_t random_op();
    grid_op_t op;
    op.func     = 2'($urandom);
    op.x_mm     = 16'($urandom);
    op.y_mm     = 16'($urandom);
    op.z_mm     = 16'($urandom);
    op.read_row = 8'($urandom);
    op.read_col = 8'($urandom);
    return op;
  endfunction

  task automatic enqueue_op(input grid_op_t op);
    pending_ops = {pending_ops, op};
  endtask

  task automatic queue_add(input int x, input int y, input int z);
    grid_op_t op;
    op = random_op();
    op.func = FUNC_ADD;
    op.x_mm = 16'(x);
    op.y_mm = 16'(y);
    op.z_mm = 16'(z);
    enqueue_op(op);
  endtask

  task automatic queue_read(input int r, input int c);
    grid_op_t op;
    op = random_op();
    op.func = FUNC_READ;
    op.read_row = 8'(r);
    op.read_col = 8'(c);
    enqueue_op(op);
  endtask

  task automatic queue_plain(input logic [1:0] func);
    grid_op_t op;
    op = random_op();
    op.func = func;
    enqueue_op(op);
  endtask

  // mostly points in the window followed by reads around them
  task automatic queue_random(input int n);
    int sel, x, y, z, ground, r, c, last_r, last_c, span;
    ground = -(grid_height_mm + 200);
    last_r = 100;
    last_c = 100;
    span = grid_half + 2;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        queue_plain(FUNC_CLEAR);
      end else if (sel < 5) begin
        queue_plain(FUNC_NONE);
      end else if (sel < 42) begin
        x = int'($urandom_range(1501, 19999));
        y = int'($urandom_range(0, 19998)) - 9999;
        if ($urandom_range(0, 9) == 0)
          z = ground - int'($urandom_range(1, 32768 + ground));
        else
          z = ground + int'($urandom_range(0, 32767 - ground));
        if (z < -32768) z = -32768;
        last_r = FORWARD_CELLS - x / 100;
        last_c = LATERAL_CELLS / 2 - y / 100;
        queue_add(x, y, z);
      end else if (sel < 46) begin
        case ($urandom_range(0, 3))
          0: x = 1500;
          1: x = 1501;
          2: x = 19999;
          default: x = 20000;
        endcase
        case ($urandom_range(0, 4))
          0: y = -10000;
          1: y = -9999;
          2: y = 9999;
          3: y = 10000;
          default: y = 0;
        endcase
        z = ground - int'($urandom_range(0, 1));
        queue_add(x, y, z);
      end else if (sel < 50) begin
        enqueue_op(random_op());
      end else if (sel < 75) begin
        r = last_r - span + int'($urandom_range(0, 2 * span));
        c = last_c - span + int'($urandom_range(0, 2 * span));
        queue_read((r < 0) ? 0 : r, (c < 0) ? 0 : c);
      end else if (sel < 93) begin
        queue_read($urandom_range(0, LATERAL_CELLS - 1), $urandom_range(0, FORWARD_CELLS - 1));
      end else begin
        queue_read($urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DAT_W'(val);
    if (idx == CFG_LIDAR_HEIGHT) grid_height_mm = val;
    else grid_half = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || start || expected_cells.size() != 0 || busy)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // driver: bursts of beats with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && n_beats != beats_sent) begin
      // hold the beat until it is taken
    end else if (idle_left > 0) begin
      start <= 1'b0;
      idle_left--;
    end else if (pending_ops.size() > 0) begin
      cur_op = pending_ops.pop_front();
      beats_sent++;
      in_func     <= cur_op.func;
      in_x_mm     <= cur_op.x_mm;
      in_y_mm     <= cur_op.y_mm;
      in_z_mm     <= cur_op.z_mm;
      in_read_row <= cur_op.read_row;
      in_read_col <= cur_op.read_col;
      start       <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 30);
        idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("unexpected result occupied %0b point_marked %0b",
                                    out_occupied, out_point_marked));
        end else begin
          want = expected_cells.pop_front();
          if (out_occupied !== want.occupied)
            report_mismatch($sformatf("func %0d occupied %b, want %b",
                                      want.func, out_occupied, want.occupied));
          if (out_point_marked !== want.point_marked)
            report_mismatch($sformatf("func %0d point_marked %b, want %b",
                                      want.func, out_point_marked, want.point_marked));
        end
      end
      if (start && !busy) begin
        want = apply_grid_op(cur_op);
        expected_cells = {expected_cells, want};
        n_beats++;
        case (cur_op.func)
          FUNC_CLEAR: n_clears++;
          FUNC_ADD: begin
            if (want.point_marked) n_painted++;
            else n_dropped++;
          end
          FUNC_READ: begin
            n_reads++;
            if (want.occupied) n_read_set++;
            if (cur_op.read_row >= LATERAL_CELLS || cur_op.read_col >= FORWARD_CELLS)
              n_read_oor++;
          end
          default: n_unused++;
        endcase
      end
    end
  end

  initial begin
    int phase_height [NUM_PHASES];
    int phase_half [NUM_PHASES];
    int h, f;
    phase_height = '{0, 5000, 2500, -1, -1, 5000, 0, -1};
    phase_half   = '{0, 15, 5, -1, -1, 0, 15, -1};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed beats at reset settings, ground cut at -1200
    queue_read(0, 0);
    queue_read(LATERAL_CELLS - 1, FORWARD_CELLS - 1);
    queue_read(255, 255);
    queue_read(LATERAL_CELLS, 0);
    queue_read(0, FORWARD_CELLS);
    queue_add(1500, 0, 0);
    queue_add(20000, 0, 0);
    queue_add(5000, 10000, 0);
    queue_add(5000, -10000, 0);
    queue_add(1501, 0, -1201);
    queue_add(1501, 0, -1200);
    queue_read(185, 100);
    queue_read(195, 110);
    queue_read(196, 100);
    queue_add(19999, 9999, 100);
    queue_read(0, 0);
    queue_add(19999, -9999, 32767);
    queue_read(0, FORWARD_CELLS - 1);
    queue_add(-32768, -32768, -32768);
    queue_add(32767, 32767, 32767);
    queue_plain(FUNC_NONE);
    queue_read(185, 100);
    queue_plain(FUNC_CLEAR);
    queue_read(185, 100);
    queue_add(5000, -50, 0);
    queue_read(150, 100);
    queue_random(150);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      h = (phase_height[p] < 0) ? int'($urandom_range(0, 5000)) : phase_height[p];
      f = (phase_half[p] < 0) ? int'($urandom_range(0, 15)) : phase_half[p];
      write_reg(CFG_LIDAR_HEIGHT, h);
      write_reg(CFG_INFLATE_HALF, f);
      n_settings++;
      queue_random(155);
      wait_drained();
    end

    $display("Covered %0d beats, %0d settings: %0d clears, %0d painted, %0d dropped, %0d unused",
             n_beats, n_settings, n_clears, n_painted, n_dropped, n_unused);
    $display("Cell reads %0d, marked %0d, out of range %0d; mismatches %0d",
             n_reads, n_read_set, n_read_oor, mismatches);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/ogi_pkg.sv
design/ogi_div100.sv
design/ogi_row_mem.sv
design/occupancy_grid_inflate_unit.sv
test/tb_occupancy_grid_inflate_unit.sv
